/* design/nfam_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFA regex matcher package
// Shared types, instruction codes and helper functions of the matcher.
// ----------------------------------------------------------------------------
package nfam_pkg;

    // Request codes as they arrive on the input port.
    localparam logic [2:0] REQ_LOAD_INSTR = 3'd0;
    localparam logic [2:0] REQ_LOAD_RANGE = 3'd1;
    localparam logic [2:0] REQ_START      = 3'd2;
    localparam logic [2:0] REQ_BYTE       = 3'd3;
    localparam logic [2:0] REQ_END        = 3'd4;

    // Instruction opcodes.
    localparam logic [3:0] OP_CHAR   = 4'd0;
    localparam logic [3:0] OP_ANY    = 4'd1;
    localparam logic [3:0] OP_IN     = 4'd2;
    localparam logic [3:0] OP_NOTIN  = 4'd3;
    localparam logic [3:0] OP_MATCH  = 4'd4;
    localparam logic [3:0] OP_JMP    = 4'd5;
    localparam logic [3:0] OP_SPLIT  = 4'd6;
    localparam logic [3:0] OP_SAVE   = 4'd7;
    localparam logic [3:0] OP_ASSERT = 4'd8;

    // Assertion kinds.
    localparam logic [7:0] AS_BOS  = 8'd0;
    localparam logic [7:0] AS_BOL  = 8'd1;
    localparam logic [7:0] AS_EOL  = 8'd2;
    localparam logic [7:0] AS_EOS  = 8'd3;
    localparam logic [7:0] AS_WB   = 8'd4;
    localparam logic [7:0] AS_NWB  = 8'd5;

    // Result status codes.
    localparam logic [1:0] ST_LOADED  = 2'd0;
    localparam logic [1:0] ST_NEED    = 2'd1;
    localparam logic [1:0] ST_MATCH   = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic [2:0] {
        CMD_LOAD_I,
        CMD_LOAD_R,
        CMD_START,
        CMD_BYTE,
        CMD_END,
        CMD_NOP
    } t_kind;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] opd;
        logic [5:0] x;
        logic [5:0] y;
    } t_instr;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] idx;
        t_instr     instr;
        logic [2:0] slot;
        logic [7:0] rlow;
        logic [7:0] rhigh;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_RUN,
        MS_MATCHED,
        MS_FAILED
    } t_mstate;

    typedef enum logic [3:0] {
        BS_IDLE,
        BS_DISPATCH,
        BS_WALK_INIT,
        BS_WALK_CHK,
        BS_WALK_THR,
        BS_WALK_OP,
        BS_RANGE_RD,
        BS_RANGE_CMP,
        BS_WALK_NEXT,
        BS_CL_POP,
        BS_CL_RD,
        BS_CL_INS,
        BS_CL_PUSH2,
        BS_RESULT
    } t_bstate;

    function automatic logic f_is_word(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

endpackage

/* design/nfa_regex_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFA regex matcher
// Thompson-style NFA matcher: program and range loads, start, data bytes and
// end of input, one status beat per request beat.
//
//   Channel   Handshake              Payload
//   request   push / full            i_req_type .. i_data_byte
//   result    empty / pop            o_status, o_live_threads
//   config    i_cfg_we               i_cfg_wdata (start_pc)
//
// A start builds the first closure; a data byte or end walks each live thread,
// tests ranges for IN and NOTIN and builds closures, as the one program memory
// port allows.
// Reset is synchronous and leaves no thread live; stores need no clearing.
// Two-deep request and result queues absorb stalls.
// ----------------------------------------------------------------------------
module nfa_regex_matcher #(
    parameter int PROG_LEN   = 64,
    parameter int MAX_RANGES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [2:0] i_req_type,
    input  logic [5:0] i_instr_index,
    input  logic [3:0] i_opcode,
    input  logic [7:0] i_operand,
    input  logic [5:0] i_target_x,
    input  logic [5:0] i_target_y,
    input  logic [2:0] i_range_slot,
    input  logic [7:0] i_range_low,
    input  logic [7:0] i_range_high,
    input  logic [7:0] i_data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_status,
    output logic [6:0] o_live_threads
);

    logic           cmd_valid;
    logic           cmd_pop;
    nfam_pkg::t_cmd cmd;

    nfam_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_req_type    (i_req_type),
        .i_instr_index (i_instr_index),
        .i_opcode      (i_opcode),
        .i_operand     (i_operand),
        .i_target_x    (i_target_x),
        .i_target_y    (i_target_y),
        .i_range_slot  (i_range_slot),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_data_byte   (i_data_byte),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    nfam_back #(.PROG_LEN(PROG_LEN), .MAX_RANGES(MAX_RANGES)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_pop      (cmd_pop),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_live_threads (o_live_threads)
    );

endmodule

/* design/nfam_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nfam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/nfam_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFA matcher front end
// Accepts request beats, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module nfam_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [2:0]       i_req_type,
    input  logic [5:0]       i_instr_index,
    input  logic [3:0]       i_opcode,
    input  logic [7:0]       i_operand,
    input  logic [5:0]       i_target_x,
    input  logic [5:0]       i_target_y,
    input  logic [2:0]       i_range_slot,
    input  logic [7:0]       i_range_low,
    input  logic [7:0]       i_range_high,
    input  logic [7:0]       i_data_byte,
    output logic             o_cmd_valid,
    output nfam_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_pop
);

    nfam_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    nfam_pkg::t_cmd w_cmd;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_cmd.idx   = i_instr_index;
        w_cmd.instr = '{op: i_opcode, opd: i_operand, x: i_target_x, y: i_target_y};
        w_cmd.slot  = i_range_slot;
        w_cmd.rlow  = i_range_low;
        w_cmd.rhigh = i_range_high;
        w_cmd.data  = i_data_byte;
        case (i_req_type)
            nfam_pkg::REQ_LOAD_INSTR: w_cmd.kind = nfam_pkg::CMD_LOAD_I;
            nfam_pkg::REQ_LOAD_RANGE: w_cmd.kind = nfam_pkg::CMD_LOAD_R;
            nfam_pkg::REQ_START:      w_cmd.kind = nfam_pkg::CMD_START;
            nfam_pkg::REQ_BYTE:       w_cmd.kind = nfam_pkg::CMD_BYTE;
            nfam_pkg::REQ_END:        w_cmd.kind = nfam_pkg::CMD_END;
            default:                  w_cmd.kind = nfam_pkg::CMD_NOP;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_cmd;
                r_wp      <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

/* design/nfam_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NFA matcher engine
// Executes queued requests: program loads, closure building, thread walks,
// and holds finished results in a two-entry queue.
// ----------------------------------------------------------------------------
module nfam_back #(
    parameter int PROG_LEN   = 64,
    parameter int MAX_RANGES = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [5:0]       i_cfg_wdata,
    input  logic             i_cmd_valid,
    input  nfam_pkg::t_cmd   i_cmd,
    output logic             o_cmd_pop,
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       o_status,
    output logic [6:0]       o_live_threads
);

    localparam int AW  = $clog2(PROG_LEN);
    localparam int PCW = (AW > 6) ? AW : 6;
    localparam int CW  = $clog2(PROG_LEN + 1);
    localparam int SD  = PROG_LEN + 2;
    localparam int SW  = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int RAW = $clog2(PROG_LEN * MAX_RANGES);
    localparam int NW  = $clog2(MAX_RANGES + 1);
    localparam int LAW = AW + 1;

    function automatic logic [AW-1:0] f_next_pc(input logic [AW-1:0] pc);
        return (pc == AW'(PROG_LEN - 1)) ? '0 : pc + 1'b1;
    endfunction

    nfam_pkg::t_bstate r_state, n_state;
    nfam_pkg::t_mstate r_mstate, n_mstate;
    nfam_pkg::t_cmd    r_cmd, n_cmd;
    logic [5:0]        r_start_pc;
    logic [CW-1:0]     r_cnt [2];
    logic [CW-1:0]     n_cnt [2];
    logic [PROG_LEN-1:0] r_vis [2];
    logic [PROG_LEN-1:0] n_vis [2];
    logic              r_cur, n_cur;
    logic              r_prev_valid, n_prev_valid;
    logic [7:0]        r_prev_byte, n_prev_byte;
    logic [CW-1:0]     r_i, n_i;
    logic [AW-1:0]     r_tpc, n_tpc;
    logic              r_tword, n_tword;
    logic [NW-1:0]     r_j, n_j;
    logic [NW-1:0]     r_rn, n_rn;
    logic              r_rin, n_rin;
    logic [SPW-1:0]    r_sp, n_sp;
    logic [AW-1:0]     r_cpc, n_cpc;
    logic              r_csel, n_csel;
    logic              r_cpv, n_cpv;
    logic [7:0]        r_cpb, n_cpb;
    logic              r_cret, n_cret;
    logic [PCW-1:0]    r_px, n_px;
    logic [1:0]        r_res_status, n_res_status;
    logic [1:0]        r_rq_status [2];
    logic [6:0]        r_rq_live [2];
    logic              r_rq_wp;
    logic              r_rq_rp;
    logic [1:0]        r_rq_cnt;

    // Memory ports
    logic              prog_we;
    logic [AW-1:0]     prog_waddr, prog_raddr;
    logic [23:0]       prog_rdata;
    logic              range_we;
    logic [RAW-1:0]    range_waddr, range_raddr;
    logic [15:0]       range_rdata;
    logic              list_we;
    logic [LAW-1:0]    list_waddr, list_raddr;
    logic [AW:0]       list_wdata, list_rdata;
    logic              stack_we;
    logic [SW-1:0]     stack_waddr, stack_raddr;
    logic [PCW-1:0]    stack_wdata, stack_rdata;

    // Closure call and push requests, resolved after the state case.
    logic              call_en, call_sel, call_pv, call_ret;
    logic [PCW-1:0]    call_pc;
    logic [7:0]        call_pb;
    logic              push_en;
    logic [PCW-1:0]    push_pc;
    logic              rq_push;

    nfam_pkg::t_instr  w_instr;
    logic              w_have;
    logic [7:0]        w_c;
    logic              w_cw;
    logic              w_hold;
    logic [AW-1:0]     w_np_walk, w_np_cl;
    logic [AW-1:0]     w_spc;
    logic [NW-1:0]     w_n;

    assign w_instr   = nfam_pkg::t_instr'(prog_rdata);
    assign w_have    = (r_cmd.kind == nfam_pkg::CMD_BYTE);
    assign w_c       = r_cmd.data;
    assign w_cw      = w_have && nfam_pkg::f_is_word(w_c);
    assign w_np_walk = f_next_pc(r_tpc);
    assign w_np_cl   = f_next_pc(r_cpc);
    assign w_spc     = stack_rdata[AW-1:0];
    assign w_n       = (w_instr.opd > 8'(MAX_RANGES)) ? NW'(MAX_RANGES) : NW'(w_instr.opd);

    always_comb begin
        case (w_instr.opd)
            nfam_pkg::AS_EOL: w_hold = !w_have || (w_c == nfam_pkg::NEWLINE_BYTE);
            nfam_pkg::AS_EOS: w_hold = !w_have;
            nfam_pkg::AS_WB:  w_hold = (r_tword != w_cw);
            nfam_pkg::AS_NWB: w_hold = (r_tword == w_cw);
            default:          w_hold = 1'b0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_mstate     = r_mstate;
        n_cmd        = r_cmd;
        n_cnt        = r_cnt;
        n_vis        = r_vis;
        n_cur        = r_cur;
        n_prev_valid = r_prev_valid;
        n_prev_byte  = r_prev_byte;
        n_i          = r_i;
        n_tpc        = r_tpc;
        n_tword      = r_tword;
        n_j          = r_j;
        n_rn         = r_rn;
        n_rin        = r_rin;
        n_sp         = r_sp;
        n_cpc        = r_cpc;
        n_csel       = r_csel;
        n_cpv        = r_cpv;
        n_cpb        = r_cpb;
        n_cret       = r_cret;
        n_px         = r_px;
        n_res_status = r_res_status;
        o_cmd_pop    = 1'b0;
        prog_we      = 1'b0;
        prog_waddr   = AW'(r_cmd.idx);
        prog_raddr   = r_tpc;
        range_we     = 1'b0;
        range_waddr  = RAW'(r_cmd.idx) * RAW'(MAX_RANGES) + RAW'(r_cmd.slot);
        range_raddr  = RAW'(r_tpc) * RAW'(MAX_RANGES) + RAW'(r_j);
        list_we      = 1'b0;
        list_waddr   = {r_csel, r_cnt[r_csel][AW-1:0]};
        list_wdata   = '0;
        list_raddr   = {r_cur, r_i[AW-1:0]};
        stack_we     = 1'b0;
        stack_waddr  = r_sp[SW-1:0];
        stack_wdata  = '0;
        stack_raddr  = SW'(r_sp - 1'b1);
        call_en      = 1'b0;
        call_sel     = 1'b0;
        call_pv      = 1'b0;
        call_pb      = '0;
        call_pc      = '0;
        call_ret     = 1'b1;
        push_en      = 1'b0;
        push_pc      = '0;
        rq_push      = 1'b0;

        case (r_state)
            nfam_pkg::BS_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = nfam_pkg::BS_DISPATCH;
                end
            end
            nfam_pkg::BS_DISPATCH: begin
                n_res_status = nfam_pkg::ST_LOADED;
                n_state      = nfam_pkg::BS_RESULT;
                case (r_cmd.kind)
                    nfam_pkg::CMD_LOAD_I: begin
                        prog_we = (11'(r_cmd.idx) < 11'(PROG_LEN));
                    end
                    nfam_pkg::CMD_LOAD_R: begin
                        range_we = (11'(r_cmd.idx) < 11'(PROG_LEN)) &&
                                   (7'(r_cmd.slot) < 7'(MAX_RANGES));
                    end
                    nfam_pkg::CMD_START: begin
                        n_cnt[0]     = '0;
                        n_cnt[1]     = '0;
                        n_vis[0]     = '0;
                        n_vis[1]     = '0;
                        n_cur        = 1'b0;
                        n_prev_valid = 1'b0;
                        n_prev_byte  = '0;
                        n_mstate     = nfam_pkg::MS_RUN;
                        n_res_status = nfam_pkg::ST_NEED;
                        call_en      = 1'b1;
                        call_pc      = PCW'(r_start_pc);
                        call_ret     = 1'b0;
                    end
                    nfam_pkg::CMD_BYTE, nfam_pkg::CMD_END: begin
                        if (r_mstate != nfam_pkg::MS_RUN) begin
                            n_res_status = (r_mstate == nfam_pkg::MS_MATCHED) ?
                                           nfam_pkg::ST_MATCH : nfam_pkg::ST_NOMATCH;
                        end else if (r_cnt[r_cur] == '0) begin
                            if (w_have) begin
                                n_res_status = nfam_pkg::ST_NEED;
                            end else begin
                                n_mstate     = nfam_pkg::MS_FAILED;
                                n_res_status = nfam_pkg::ST_NOMATCH;
                            end
                        end else begin
                            n_state = nfam_pkg::BS_WALK_INIT;
                        end
                    end
                    default: begin
                        n_res_status = nfam_pkg::ST_LOADED;
                    end
                endcase
            end
            nfam_pkg::BS_WALK_INIT: begin
                n_cnt[~r_cur] = '0;
                n_vis[~r_cur] = '0;
                n_i           = '0;
                n_state       = nfam_pkg::BS_WALK_CHK;
            end
            nfam_pkg::BS_WALK_CHK: begin
                // The current list may grow while it is walked (held assertions).
                if (r_i < r_cnt[r_cur]) begin
                    n_state = nfam_pkg::BS_WALK_THR;
                end else begin
                    n_cnt[r_cur] = '0;
                    n_vis[r_cur] = '0;
                    n_cur        = ~r_cur;
                    if (w_have) begin
                        n_prev_valid = 1'b1;
                        n_prev_byte  = w_c;
                        n_res_status = nfam_pkg::ST_NEED;
                    end else begin
                        n_mstate     = nfam_pkg::MS_FAILED;
                        n_res_status = nfam_pkg::ST_NOMATCH;
                    end
                    n_state = nfam_pkg::BS_RESULT;
                end
            end
            nfam_pkg::BS_WALK_THR: begin
                n_tpc      = list_rdata[AW-1:0];
                n_tword    = list_rdata[AW];
                prog_raddr = list_rdata[AW-1:0];
                n_state    = nfam_pkg::BS_WALK_OP;
            end
            nfam_pkg::BS_WALK_OP: begin
                n_state  = nfam_pkg::BS_WALK_NEXT;
                call_sel = ~r_cur;
                call_pv  = 1'b1;
                call_pb  = w_c;
                call_pc  = PCW'(w_np_walk);
                case (w_instr.op)
                    nfam_pkg::OP_CHAR: call_en = w_have && (w_c == w_instr.opd);
                    nfam_pkg::OP_ANY:  call_en = w_have;
                    nfam_pkg::OP_IN, nfam_pkg::OP_NOTIN: begin
                        if (w_have) begin
                            n_j     = '0;
                            n_rn    = w_n;
                            n_rin   = (w_instr.op == nfam_pkg::OP_IN);
                            n_state = nfam_pkg::BS_RANGE_RD;
                        end
                    end
                    nfam_pkg::OP_MATCH: begin
                        n_mstate     = nfam_pkg::MS_MATCHED;
                        n_res_status = nfam_pkg::ST_MATCH;
                        n_state      = nfam_pkg::BS_RESULT;
                    end
                    nfam_pkg::OP_ASSERT: begin
                        call_en  = w_hold;
                        call_sel = r_cur;
                        call_pv  = r_prev_valid;
                        call_pb  = r_prev_byte;
                    end
                    default: begin
                        n_state = nfam_pkg::BS_WALK_NEXT;
                    end
                endcase
            end
            nfam_pkg::BS_RANGE_RD: begin
                call_sel = ~r_cur;
                call_pv  = 1'b1;
                call_pb  = w_c;
                call_pc  = PCW'(w_np_walk);
                if (r_j < r_rn) begin
                    n_state = nfam_pkg::BS_RANGE_CMP;
                end else begin
                    call_en = !r_rin;
                    n_state = nfam_pkg::BS_WALK_NEXT;
                end
            end
            nfam_pkg::BS_RANGE_CMP: begin
                call_sel = ~r_cur;
                call_pv  = 1'b1;
                call_pb  = w_c;
                call_pc  = PCW'(w_np_walk);
                if (w_c >= range_rdata[15:8] && w_c <= range_rdata[7:0]) begin
                    call_en = r_rin;
                    n_state = nfam_pkg::BS_WALK_NEXT;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = nfam_pkg::BS_RANGE_RD;
                end
            end
            nfam_pkg::BS_WALK_NEXT: begin
                n_i     = r_i + 1'b1;
                n_state = nfam_pkg::BS_WALK_CHK;
            end
            nfam_pkg::BS_CL_POP: begin
                if (r_sp == '0) begin
                    n_state = r_cret ? nfam_pkg::BS_WALK_NEXT : nfam_pkg::BS_RESULT;
                end else begin
                    n_sp    = r_sp - 1'b1;
                    n_state = nfam_pkg::BS_CL_RD;
                end
            end
            nfam_pkg::BS_CL_RD: begin
                if ({1'b0, stack_rdata} >= (PCW + 1)'(PROG_LEN) || r_vis[r_csel][w_spc]) begin
                    n_state = nfam_pkg::BS_CL_POP;
                end else begin
                    n_vis[r_csel][w_spc] = 1'b1;
                    prog_raddr           = w_spc;
                    n_cpc                = w_spc;
                    n_state              = nfam_pkg::BS_CL_INS;
                end
            end
            nfam_pkg::BS_CL_INS: begin
                n_state = nfam_pkg::BS_CL_POP;
                case (w_instr.op)
                    nfam_pkg::OP_JMP: begin
                        push_en = 1'b1;
                        push_pc = PCW'(w_instr.x);
                    end
                    nfam_pkg::OP_SPLIT: begin
                        push_en = 1'b1;
                        push_pc = PCW'(w_instr.y);
                        n_px    = PCW'(w_instr.x);
                        n_state = nfam_pkg::BS_CL_PUSH2;
                    end
                    nfam_pkg::OP_SAVE: begin
                        push_en = 1'b1;
                        push_pc = PCW'(w_np_cl);
                    end
                    default: begin
                        if (w_instr.op == nfam_pkg::OP_ASSERT &&
                            w_instr.opd == nfam_pkg::AS_BOS) begin
                            push_en = !r_cpv;
                            push_pc = PCW'(w_np_cl);
                        end else if (w_instr.op == nfam_pkg::OP_ASSERT &&
                                     w_instr.opd == nfam_pkg::AS_BOL) begin
                            push_en = !r_cpv || (r_cpb == nfam_pkg::NEWLINE_BYTE);
                            push_pc = PCW'(w_np_cl);
                        end else if (r_cnt[r_csel] < CW'(PROG_LEN)) begin
                            list_we    = 1'b1;
                            list_wdata = {(w_instr.op == nfam_pkg::OP_ASSERT) &&
                                          (w_instr.opd == nfam_pkg::AS_WB ||
                                           w_instr.opd == nfam_pkg::AS_NWB) &&
                                          r_cpv && nfam_pkg::f_is_word(r_cpb),
                                          r_cpc};
                            n_cnt[r_csel] = r_cnt[r_csel] + 1'b1;
                        end
                    end
                endcase
            end
            nfam_pkg::BS_CL_PUSH2: begin
                push_en = 1'b1;
                push_pc = r_px;
                n_state = nfam_pkg::BS_CL_POP;
            end
            nfam_pkg::BS_RESULT: begin
                if (r_rq_cnt != 2'd2) begin
                    rq_push = 1'b1;
                    n_state = nfam_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = nfam_pkg::BS_IDLE;
            end
        endcase

        // A closure starts with its seed alone on the stack.
        if (call_en) begin
            stack_we    = 1'b1;
            stack_waddr = '0;
            stack_wdata = call_pc;
            n_sp        = SPW'(1);
            n_csel      = call_sel;
            n_cpv       = call_pv;
            n_cpb       = call_pb;
            n_cret      = call_ret;
            n_state     = nfam_pkg::BS_CL_POP;
        end
        if (push_en && r_sp < SPW'(SD)) begin
            stack_we    = 1'b1;
            stack_waddr = r_sp[SW-1:0];
            stack_wdata = push_pc;
            n_sp        = r_sp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= nfam_pkg::BS_IDLE;
            r_mstate     <= nfam_pkg::MS_IDLE;
            r_start_pc   <= '0;
            r_cnt[0]     <= '0;
            r_cnt[1]     <= '0;
            r_vis[0]     <= '0;
            r_vis[1]     <= '0;
            r_cur        <= 1'b0;
            r_prev_valid <= 1'b0;
            r_prev_byte  <= '0;
            r_sp         <= '0;
            r_rq_wp      <= 1'b0;
            r_rq_rp      <= 1'b0;
            r_rq_cnt     <= 2'd0;
        end else begin
            r_state      <= n_state;
            r_mstate     <= n_mstate;
            r_cnt        <= n_cnt;
            r_vis        <= n_vis;
            r_cur        <= n_cur;
            r_prev_valid <= n_prev_valid;
            r_prev_byte  <= n_prev_byte;
            r_sp         <= n_sp;
            if (i_cfg_we) begin
                r_start_pc <= i_cfg_wdata;
            end
            if (rq_push) begin
                r_rq_wp <= ~r_rq_wp;
            end
            if (pop && !empty) begin
                r_rq_rp <= ~r_rq_rp;
            end
            r_rq_cnt <= r_rq_cnt + {1'b0, rq_push} - {1'b0, pop && !empty};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_i          <= n_i;
        r_tpc        <= n_tpc;
        r_tword      <= n_tword;
        r_j          <= n_j;
        r_rn         <= n_rn;
        r_rin        <= n_rin;
        r_cpc        <= n_cpc;
        r_csel       <= n_csel;
        r_cpv        <= n_cpv;
        r_cpb        <= n_cpb;
        r_cret       <= n_cret;
        r_px         <= n_px;
        r_res_status <= n_res_status;
        if (rq_push) begin
            r_rq_status[r_rq_wp] <= r_res_status;
            r_rq_live[r_rq_wp]   <= 7'(r_cnt[r_cur]);
        end
    end

    assign empty          = (r_rq_cnt == 2'd0);
    assign o_status       = r_rq_status[r_rq_rp];
    assign o_live_threads = r_rq_live[r_rq_rp];

    nfam_ram #(.WIDTH(24), .DEPTH(PROG_LEN)) u_prog (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (prog_waddr),
        .i_wdata (r_cmd.instr),
        .i_raddr (prog_raddr),
        .o_rdata (prog_rdata)
    );

    nfam_ram #(.WIDTH(16), .DEPTH(PROG_LEN * MAX_RANGES)) u_range (
        .i_clk   (i_clk),
        .i_we    (range_we),
        .i_waddr (range_waddr),
        .i_wdata ({r_cmd.rlow, r_cmd.rhigh}),
        .i_raddr (range_raddr),
        .o_rdata (range_rdata)
    );

    nfam_ram #(.WIDTH(AW + 1), .DEPTH(2 ** LAW)) u_list (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_raddr (list_raddr),
        .o_rdata (list_rdata)
    );

    nfam_ram #(.WIDTH(PCW), .DEPTH(2 ** SW)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (stack_wdata),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CW'(PROG_LEN)) && (r_cnt[1] <= CW'(PROG_LEN)))
        else $error("thread count exceeds program length");

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(SD))
        else $error("closure stack overflow");

    a_walk_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfam_pkg::BS_WALK_OP) |-> (r_mstate == nfam_pkg::MS_RUN))
        else $error("thread walk outside a running match");

    a_rq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rq_push |-> (r_rq_cnt != 2'd2))
        else $error("result pushed into a full queue");

endmodule
